### hw/rtl/mexp_pkg.sv
package mexp_pkg;

    // field widths
    localparam int MOD_W  = 31;
    localparam int BASE_W = 63;
    // bit counter of the modular multiply unit, holds up to BASE_W
    localparam int CNT_W  = $clog2(BASE_W + 1);

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    // request to the shared modular multiply unit
    typedef struct packed {
        logic              start;
        logic [MOD_W-1:0]  a;      // addend, below the modulus
        logic [BASE_W-1:0] b;      // multiplier, scanned from its top bit
        logic [CNT_W-1:0]  nbits;  // number of multiplier bits to scan
    } t_mm_req;

    // status from the shared modular multiply unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MOD_W-1:0] result;
    } t_mm_rsp;

endpackage

### hw/rtl/mexp_if.sv
// request channel: one word per exponentiation
interface mexp_req_if;
    import mexp_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] exponent;

    modport source (output valid, output req_type, output base, output exponent,
                    input ready);
    modport sink   (input valid, input req_type, input base, input exponent,
                    output ready);
endinterface

// result channel: one word per request
interface mexp_rsp_if;
    import mexp_pkg::*;

    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

### hw/rtl/modular_exponentiation.sv
// Modular exponentiation, base^exponent mod modulus, right-to-left
// square-and-multiply.
// i_req carries req_type, base and exponent; a word is taken when valid and
// ready are high at a clock edge. req_type 1 computes base^(modulus-2), the
// inverse for a prime modulus. o_rsp returns one result word per request.
// i_cfg_we/i_cfg_wdata write the modulus; write it only while idle.
// The base is first reduced, then each exponent bit costs a square, with a
// multiply before it when the bit is set; the scan stops after the top set
// bit. Every step runs on the single bit-serial modular multiply unit that
// all steps share. A modulus below two gives 0 without using that unit.
// One request is in flight at a time; i_req.ready is high only when the
// sequencer is idle.
// The result sits in an output register, so a new request is taken while
// the previous word still waits; if the receiver stalls, the finished word
// waits in the sequencer until the output register frees.
// Reset (synchronous, active low) drops any request in flight, empties the
// output register and sets the modulus to 1000000007.
module modular_exponentiation #(
    parameter int EXPONENT_BITS = 63
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mexp_req_if.sink                   i_req,
    mexp_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  logic [mexp_pkg::MOD_W-1:0] i_cfg_wdata
);
    import mexp_pkg::*;

    // exponent register also holds modulus - 2 in inverse mode
    localparam int EW = (EXPONENT_BITS > MOD_W) ? EXPONENT_BITS : MOD_W;
    localparam int PAD_W = BASE_W - MOD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_LOOP,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

    t_state           r_state;
    logic [MOD_W-1:0] r_modulus;
    logic [MOD_W-1:0] r_acc;
    logic [MOD_W-1:0] r_sq;
    logic [EW-1:0]    r_exp;
    logic [MOD_W-1:0] r_result;
    logic             r_out_valid;
    t_mm_req          r_mm_req;
    t_mm_rsp          w_mm_rsp;

    logic             w_accept;

    assign w_accept = i_req.valid && i_req.ready;

    // shared modular multiply unit
    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_req     (r_mm_req),
        .o_rsp     (w_mm_rsp)
    );

    // sequencer, modulus register and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_mm_req.start <= 1'b0;
            r_modulus      <= MODULUS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            // output register: load a finished word, else clear once taken
            if (r_state == ST_DONE && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (r_modulus < MOD_W'(2)) begin
                            // modulus of zero or one: everything is 0
                            r_acc          <= '0;
                            r_mm_req.start <= 1'b0;
                            r_state        <= ST_DONE;
                        end else begin
                            r_acc <= MOD_W'(1);
                            if (i_req.req_type) begin
                                r_exp <= EW'(r_modulus - MOD_W'(2));
                            end else begin
                                r_exp <= EW'(i_req.exponent[EXPONENT_BITS-1:0]);
                            end
                            // base mod m as base * 1
                            r_mm_req.a     <= MOD_W'(1);
                            r_mm_req.b     <= i_req.base;
                            r_mm_req.nbits <= CNT_W'(BASE_W);
                            r_mm_req.start <= 1'b1;
                            r_state        <= ST_REDUCE;
                        end
                    end else begin
                        r_mm_req.start <= 1'b0;
                    end
                end
                ST_REDUCE: begin
                    r_mm_req.start <= 1'b0;
                    if (w_mm_rsp.done) begin
                        r_sq    <= w_mm_rsp.result;
                        r_state <= ST_LOOP;
                    end
                end
                ST_LOOP: begin
                    if (r_exp == '0) begin
                        r_mm_req.start <= 1'b0;
                        r_state        <= ST_DONE;
                    end else if (r_exp[0]) begin
                        r_mm_req.a     <= r_acc;
                        r_mm_req.b     <= {r_sq, {PAD_W{1'b0}}};
                        r_mm_req.nbits <= CNT_W'(MOD_W);
                        r_mm_req.start <= 1'b1;
                        r_state        <= ST_MUL;
                    end else begin
                        r_mm_req.a     <= r_sq;
                        r_mm_req.b     <= {r_sq, {PAD_W{1'b0}}};
                        r_mm_req.nbits <= CNT_W'(MOD_W);
                        r_mm_req.start <= 1'b1;
                        r_state        <= ST_SQR;
                    end
                end
                ST_MUL: begin
                    // multiply done, square follows
                    if (w_mm_rsp.done) begin
                        r_acc          <= w_mm_rsp.result;
                        r_mm_req.a     <= r_sq;
                        r_mm_req.b     <= {r_sq, {PAD_W{1'b0}}};
                        r_mm_req.nbits <= CNT_W'(MOD_W);
                        r_mm_req.start <= 1'b1;
                        r_state        <= ST_SQR;
                    end else begin
                        r_mm_req.start <= 1'b0;
                    end
                end
                ST_SQR: begin
                    r_mm_req.start <= 1'b0;
                    if (w_mm_rsp.done) begin
                        r_sq    <= w_mm_rsp.result;
                        r_exp   <= r_exp >> 1;
                        r_state <= ST_LOOP;
                    end
                end
                ST_DONE: begin
                    // hand over once the output register is free
                    r_mm_req.start <= 1'b0;
                    if (!r_out_valid || o_rsp.ready) begin
                        r_result <= r_acc;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_mm_req.start <= 1'b0;
                    r_state        <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready  = (r_state == ST_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.result = r_result;

    // checks
    a_done_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_rsp.done |-> (r_state == ST_REDUCE || r_state == ST_MUL ||
                           r_state == ST_SQR))
        else $error("multiply unit finished outside an operation");

    a_ready_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !w_mm_rsp.busy)
        else $error("request taken while multiply unit busy");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("accepted word did not start an operation");

    a_done_hands_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_out_valid) |=> r_out_valid)
        else $error("finished result not moved to output register");

endmodule

### hw/rtl/mexp_mulmod.sv
// Interleaved modular multiply: r = (2r + bit*a) mod m, one multiplier bit
// per cycle from the top. Also reduces a wide value when a = 1.
module mexp_mulmod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mexp_pkg::MOD_W-1:0] i_modulus,
    input  mexp_pkg::t_mm_req          i_req,
    output mexp_pkg::t_mm_rsp          o_rsp
);
    import mexp_pkg::*;

    logic [MOD_W-1:0]  r_r;
    logic [MOD_W-1:0]  r_a;
    logic [BASE_W-1:0] r_b;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [MOD_W+1:0]  w_t;
    logic [MOD_W+1:0]  w_m1;
    logic [MOD_W+1:0]  w_m2;
    logic [MOD_W-1:0]  n_r;

    // one step: double, add, then take off m or 2m (sum stays below 3m)
    always_comb begin
        w_m1 = {2'b00, i_modulus};
        w_m2 = {1'b0, i_modulus, 1'b0};
        w_t  = {1'b0, r_r, 1'b0} + {2'b00, (r_b[BASE_W-1] ? r_a : {MOD_W{1'b0}})};
        priority if (w_t >= w_m2) begin
            n_r = MOD_W'(w_t - w_m2);
        end else if (w_t >= w_m1) begin
            n_r = MOD_W'(w_t - w_m1);
        end else begin
            n_r = MOD_W'(w_t);
        end
    end

    // bit counter and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_r    <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_cnt  <= i_req.nbits;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r   <= n_r;
                r_b   <= {r_b[BASE_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_r;

endmodule

### test/mexp_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and modulus ports of the exponentiation block,
// predicts every result word and compares it with what comes out.
module mexp_checker #(
    parameter int EXPONENT_BITS = 63
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mexp_req_if                        i_req,
    mexp_rsp_if                        i_rsp,
    input  logic                       i_cfg_we,
    input  logic [mexp_pkg::MOD_W-1:0] i_cfg_wdata,
    output int                         o_mismatches,
    output int                         o_outstanding
);
    import mexp_pkg::*;

    // only the low EXPONENT_BITS of the exponent take part
    localparam logic [63:0] EXP_MASK =
        (EXPONENT_BITS >= 64) ? '1 : ((64'd1 << EXPONENT_BITS) - 64'd1);
    // beyond this many lines mismatches are only counted
    localparam int PRINT_CAP = 40;

    logic [MOD_W-1:0] modulus_model;
    logic [MOD_W-1:0] expected_powers [$];
    logic [MOD_W-1:0] want;
    int               mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // base^exponent mod m, right-to-left square-and-multiply;
    // inverse mode swaps the exponent for m - 2
    function automatic logic [MOD_W-1:0] mod_power(
        input logic              inverse,
        input logic [BASE_W-1:0] base,
        input logic [BASE_W-1:0] exponent,
        input logic [MOD_W-1:0]  m
    );
        logic [63:0] acc;
        logic [63:0] run;
        logic [63:0] mm;
        logic [63:0] e;
        if (m == '0)
            return '0;
        mm = 64'(m);
        if (inverse)
            e = (mm >= 64'd2) ? mm - 64'd2 : 64'd0;
        else
            e = 64'(exponent) & EXP_MASK;
        acc = 64'd1 % mm;
        run = 64'(base) % mm;
        // operands stay below 2^31, so the products fit in 64 bits
        while (e != 64'd0) begin
            if (e[0])
                acc = (acc * run) % mm;
            run = (run * run) % mm;
            e   = e >> 1;
        end
        return acc[MOD_W-1:0];
    endfunction

    task automatic report(input string what, input logic [MOD_W-1:0] got,
                          input logic [MOD_W-1:0] exp_val);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mexp_checker: %0t ns: %s: got %0d, want %0d",
                     $time, what, got, exp_val);
    endtask

    // sample both channels and the modulus port on every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_model = MODULUS_RESET;
            expected_powers.delete();
        end else begin
            if (i_cfg_we)
                modulus_model = i_cfg_wdata;
            // result first: a word leaving with nothing queued is spurious
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_powers.size() == 0) begin
                    report("result word with none pending", i_rsp.result, '0);
                end else begin
                    want = expected_powers.pop_front();
                    if (i_rsp.result !== want)
                        report("result word mismatch", i_rsp.result, want);
                end
            end
            // queue the prediction at the tail
            if (i_req.valid && i_req.ready)
                expected_powers = {expected_powers,
                                   mod_power(i_req.req_type, i_req.base,
                                             i_req.exponent, modulus_model)};
        end
        o_outstanding <= expected_powers.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mexp_pkg::*;

    localparam int   EXP_BITS        = 63;
    localparam int   RANDOM_PHASES   = 8;
    localparam int   WORDS_PER_PHASE = 100;
    localparam int   HOLD_PHASE      = 4;
    localparam int   LONG_HOLD       = 10000;
    localparam int   SETTLE_CYCLES   = 4300;
    localparam int   CYCLE_LIMIT     = 20_000_000;
    localparam logic REQ_POWER       = 1'b0;
    localparam logic REQ_INVERSE     = 1'b1;
    localparam logic [BASE_W-1:0] BASE_MAX = '1;
    localparam logic [BASE_W-1:0] M_RST    = BASE_W'(MODULUS_RESET);

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [MOD_W-1:0] cfg_wdata;
    int               mismatches;
    int               outstanding;
    int               cycle_count = 0;
    logic [MOD_W-1:0] modulus_now;
    bit               hold_request = 1'b0;
    int               send_run = 0;
    bit               send_steady = 1'b0;
    int               recv_run = 0;
    bit               recv_steady = 1'b0;

    mexp_req_if req_ch();
    mexp_rsp_if rsp_ch();

    modular_exponentiation #(
        .EXPONENT_BITS(EXP_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    mexp_checker #(
        .EXPONENT_BITS(EXP_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic logic [BASE_W-1:0] rand63();
        return BASE_W'({$urandom, $urandom});
    endfunction

    // idle cycles before the next word; each run of words is drawn as either
    // random gaps or back-to-back traffic, the latter about one run in four
    task automatic draw_gap(inout int run_left, inout bit steady, output int gap);
        if (run_left == 0) begin
            run_left = $urandom_range(16, 64);
            steady   = ($urandom_range(0, 3) == 0);
        end
        run_left = run_left - 1;
        gap = steady ? 0 : $urandom_range(0, 7);
    endtask

    // offer one request word and hold it until taken; valid stays high after
    task automatic send_word(input logic kind, input logic [BASE_W-1:0] base,
                             input logic [BASE_W-1:0] exponent);
        int gap;
        draw_gap(send_run, send_steady, gap);
        if (gap != 0) begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= 1'($urandom);
            req_ch.base     <= rand63();
            req_ch.exponent <= rand63();
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.base     <= base;
        req_ch.exponent <= exponent;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // stop offering and wait for every result word to come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [MOD_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        modulus_now = value;
    endtask

    function automatic logic [MOD_W-1:0] phase_modulus(input int phase);
        case (phase)
            0:       return MODULUS_RESET;
            1:       return '1;                  // 2^31 - 1, prime
            2:       return MOD_W'(2);
            3:       return MOD_W'(3);
            4:       return MOD_W'(65537);
            5:       return MOD_W'(998244353);
            6:       return MOD_W'($urandom_range(2, 1000));
            default: return MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
        endcase
    endfunction

    // random words; exponents are mostly short so the scan stays brief
    task automatic send_random_phase(input int count, input bit with_hold);
        logic              kind;
        logic [BASE_W-1:0] base;
        logic [BASE_W-1:0] exponent;
        logic [63:0]       wide;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(0, 5) == 0) ? REQ_INVERSE : REQ_POWER;
            case ($urandom_range(0, 7))
                0: base = '0;
                1: base = BASE_MAX;
                2: begin
                    // multiple of the modulus
                    wide = 64'(modulus_now) * 64'($urandom_range(1, 4096));
                    base = wide[BASE_W-1:0];
                end
                3: base = BASE_W'(modulus_now) - BASE_W'($urandom_range(0, 1));
                4: base = BASE_W'($urandom);
                default: base = rand63();
            endcase
            case ($urandom_range(0, 31))
                0:       exponent = rand63();
                1:       exponent = '0;
                default: exponent = rand63() >> (BASE_W - $urandom_range(1, 10));
            endcase
            if (with_hold && n == count / 2)
                hold_request = 1'b1;
            send_word(kind, base, exponent);
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            draw_gap(recv_run, recv_steady, gap);
            if (hold_request) begin
                hold_request = 1'b0;
                gap          = LONG_HOLD;
            end
            if (gap != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
        end
    end

    // stimulus and verdict
    initial begin
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_POWER;
        req_ch.base     <= '0;
        req_ch.exponent <= '0;
        modulus_now     = MODULUS_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset modulus: field extremes, zero exponent, multiples, inverses
        send_word(REQ_POWER,   '0,             '0);
        send_word(REQ_POWER,   BASE_MAX,       BASE_MAX);
        send_word(REQ_POWER,   '0,             63'd5);
        send_word(REQ_POWER,   M_RST,          63'd3);
        send_word(REQ_POWER,   M_RST * 2,      '0);
        send_word(REQ_POWER,   63'd2,          63'd10);
        send_word(REQ_POWER,   M_RST - 1,      63'd2);
        send_word(REQ_POWER,   63'd1,          BASE_MAX);
        send_word(REQ_POWER,   63'd3,          63'd1 << 62);
        send_word(REQ_INVERSE, 63'd2,          '0);
        send_word(REQ_INVERSE, M_RST - 1,      BASE_MAX);
        send_word(REQ_INVERSE, '0,             63'd7);

        // smallest meaningful modulus
        write_modulus(MOD_W'(2));
        send_word(REQ_POWER,   BASE_MAX,       63'd3);
        send_word(REQ_INVERSE, 63'd5,          '0);
        send_word(REQ_POWER,   63'd4,          63'd9);

        // largest modulus
        write_modulus('1);
        send_word(REQ_POWER,   BASE_MAX,       BASE_MAX);
        send_word(REQ_INVERSE, 63'h7FFF_FFFE,  '0);
        send_word(REQ_POWER,   63'h7FFF_FFFF,  63'd1);
        send_word(REQ_POWER,   63'h7FFF_FFFE,  63'd2);

        // modulus one and zero reduce everything to 0
        write_modulus(MOD_W'(1));
        send_word(REQ_POWER,   63'd5,          '0);
        send_word(REQ_INVERSE, 63'd7,          '0);
        write_modulus('0);
        send_word(REQ_POWER,   63'd5,          '0);
        send_word(REQ_INVERSE, 63'd7,          63'd3);

        // inverse mode with a composite modulus
        write_modulus(MOD_W'(4));
        send_word(REQ_INVERSE, 63'd3,          '0);
        send_word(REQ_INVERSE, 63'd2,          '0);

        // random phases, one modulus each
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_modulus(phase_modulus(phase));
            send_random_phase(WORDS_PER_PHASE, phase == HOLD_PHASE);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
